FILE: src/json_stream_tokenizer_top_defines.svh
// Assertion helpers shared by the tokenizer top level.
`ifndef JSON_STREAM_TOKENIZER_TOP_DEFINES_SVH
`define JSON_STREAM_TOKENIZER_TOP_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define JST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define JST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/jst_pkg.sv
`default_nettype none
package jst_pkg;
    localparam logic [3:0] K_STRBYTE = 4'd0;
    localparam logic [3:0] K_KEYEND  = 4'd1;
    localparam logic [3:0] K_STREND  = 4'd2;
    localparam logic [3:0] K_NUMBYTE = 4'd3;
    localparam logic [3:0] K_NUMEND  = 4'd4;
    localparam logic [3:0] K_TRUE    = 4'd5;
    localparam logic [3:0] K_FALSE   = 4'd6;
    localparam logic [3:0] K_NULL    = 4'd7;
    localparam logic [3:0] K_OBJBEG  = 4'd8;
    localparam logic [3:0] K_OBJEND  = 4'd9;
    localparam logic [3:0] K_ARRBEG  = 4'd10;
    localparam logic [3:0] K_ARREND  = 4'd11;
    localparam logic [3:0] K_DOCEND  = 4'd12;
    localparam logic [3:0] K_ERROR   = 4'd13;

    localparam logic [2:0] E_UNRECOGNIZED = 3'd0;
    localparam logic [2:0] E_BAD_ESCAPE   = 3'd1;
    localparam logic [2:0] E_UNTERMINATED = 3'd2;
    localparam logic [2:0] E_EXPECT_QUOTE = 3'd3;
    localparam logic [2:0] E_EXPECT_COLON = 3'd4;
    localparam logic [2:0] E_BAD_NUMBER   = 3'd5;
    localparam logic [2:0] E_TOO_DEEP     = 3'd6;

    localparam logic [3:0] ADDR_MAX_DEPTH = 4'd0;

    // One result event of the lexer.
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data_byte;
        logic [2:0] error_code;
        logic [6:0] nesting;
    } event_t;

    // Stack request from the lexer to the cell chain.
    typedef struct packed {
        logic push;
        logic pop;
        logic is_array;
        logic clear;
    } stack_cmd_t;
endpackage
`default_nettype wire

FILE: src/jst_stack_cell.sv
`default_nettype none
// One entry of the container stack. On a push each cell takes the bit of its
// upper neighbor; on a pop it takes the bit of its lower neighbor.
module jst_stack_cell (
    input  wire logic               clk,
    input  wire jst_pkg::stack_cmd_t cmd,
    input  wire logic               from_above,
    input  wire logic               from_below,
    output logic                    bit_out
);
    logic bit_reg;
    logic bit_next;

    always_comb
    begin
        bit_next = bit_reg;
        if (cmd.push)
        begin
            bit_next = from_above;
        end
        else if (cmd.pop)
        begin
            bit_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

    assign bit_out = bit_reg;
endmodule
`default_nettype wire

FILE: src/jst_stack_chain.sv
`default_nettype none
// Container stack as a shift chain: cell 0 always holds the innermost kind.
module jst_stack_chain #(
    parameter int DEPTH = 64
) (
    input  wire logic               clk,
    input  wire jst_pkg::stack_cmd_t cmd,
    output logic                    top_is_array
);
    logic [DEPTH-1:0] bits;
    logic [DEPTH:0]   below;

    assign below[DEPTH] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic above;
            if (g == 0)
            begin : g_head
                assign above = cmd.is_array;
            end
            else
            begin : g_body
                assign above = bits[g-1];
            end
            assign below[g] = bits[g];
            jst_stack_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .from_above (above),
                .from_below (below[g+1]),
                .bit_out    (bits[g])
            );
        end
    endgenerate

    assign top_is_array = bits[0];
endmodule
`default_nettype wire

FILE: src/jst_lexer.sv
`default_nettype none
module jst_lexer #(
    parameter int MAX_NESTING = 64,
    parameter int LW = 7
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         b,
    input  wire logic               start,
    input  wire logic [6:0]         max_depth,
    input  wire logic               top_is_array,
    output jst_pkg::stack_cmd_t     cmd,
    output jst_pkg::event_t         ev0,
    output jst_pkg::event_t         ev1,
    output jst_pkg::event_t         ev2,
    output logic [1:0]              ev_cnt
);
    localparam logic [4:0] PH_VALUE = 5'd0, PH_VOC = 5'd1, PH_OBJ_FIRST = 5'd2,
        PH_OBJ_KEY = 5'd3, PH_COLON = 5'd4, PH_AFTER = 5'd5, PH_STRING = 5'd6,
        PH_ESCAPE = 5'd7, PH_HEX = 5'd8, PH_NUM_INT = 5'd9, PH_NUM_FRAC = 5'd10,
        PH_NUM_EXPSIGN = 5'd11, PH_NUM_EXPDIG = 5'd12, PH_LIT_TRUE = 5'd13,
        PH_LIT_FALSE = 5'd14, PH_LIT_NULL = 5'd15, PH_DONE = 5'd16,
        PH_ERROR = 5'd17;

    logic [4:0]    phase_reg, phase_next;
    logic [LW-1:0] level_reg, level_next;
    logic [15:0]   hex_reg, hex_next;
    logic [2:0]    hcnt_reg, hcnt_next;
    logic [2:0]    lpos_reg, lpos_next;
    logic          key_reg, key_next;
    logic          done_reg, done_next;

    always_comb
    begin
        logic [4:0]    ph;
        logic [LW-1:0] lv;
        logic          ws, dig, in_arr, closing, close_arr, opening, open_arr;
        logic          vdone, after_chk, ok;
        logic [LW:0]   lim;
        logic [3:0]    hv;
        logic          hok;
        logic [15:0]   u;
        logic [7:0]    want;
        logic [2:0]    llen;
        jst_pkg::event_t e [3];
        logic [1:0]    n;
        logic [2:0]    fcode;
        logic          fl;

        ph = phase_reg; lv = level_reg;
        hex_next = hex_reg; hcnt_next = hcnt_reg; lpos_next = lpos_reg;
        key_next = key_reg; done_next = done_reg;
        if (start)
        begin
            ph = PH_VALUE; lv = '0; hex_next = '0; hcnt_next = '0;
            lpos_next = '0; key_next = 1'b0; done_next = 1'b0;
        end
        phase_next = ph; level_next = lv;
        cmd = '0;
        cmd.clear = start;
        for (int i = 0; i < 3; i++)
        begin
            e[i] = '0;
        end
        n = '0;
        fl = 1'b0; fcode = jst_pkg::E_UNRECOGNIZED;
        closing = 1'b0; close_arr = 1'b0; opening = 1'b0; open_arr = 1'b0;
        vdone = 1'b0; after_chk = 1'b0; u = '0; hv = '0; hok = 1'b0;
        want = '0; llen = 3'd4; ok = 1'b0;
        ws = (b == 8'h20) || (b == 8'h0D) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B);
        dig = (b >= 8'h30) && (b <= 8'h39);
        in_arr = (lv != '0) && top_is_array;
        lim = (LW+1)'(max_depth) < (LW+1)'(MAX_NESTING) ? (LW+1)'(max_depth)
            : (LW+1)'(MAX_NESTING);
        if (dig)
        begin
            hv = 4'(b - 8'h30); hok = 1'b1;
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            hv = 4'(b - 8'h57); hok = 1'b1;
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            hv = 4'(b - 8'h37); hok = 1'b1;
        end

        case (ph)
            PH_VALUE, PH_VOC:
            begin
                if (ws)
                begin
                end
                else if (b == 8'h7B)
                begin
                    opening = 1'b1;
                end
                else if (b == 8'h5B)
                begin
                    opening = 1'b1; open_arr = 1'b1;
                end
                else if (b == 8'h22)
                begin
                    key_next = 1'b0; phase_next = PH_STRING;
                end
                else if (b == 8'h2D || dig)
                begin
                    e[0].kind = jst_pkg::K_NUMBYTE; e[0].data_byte = b; n = 2'd1;
                    phase_next = PH_NUM_INT;
                end
                else if (b == 8'h74)
                begin
                    phase_next = PH_LIT_TRUE; lpos_next = 3'd1;
                end
                else if (b == 8'h66)
                begin
                    phase_next = PH_LIT_FALSE; lpos_next = 3'd1;
                end
                else if (b == 8'h6E)
                begin
                    phase_next = PH_LIT_NULL; lpos_next = 3'd1;
                end
                else if (b == 8'h5D && ph == PH_VOC)
                begin
                    closing = 1'b1; close_arr = 1'b1;
                end
                else
                begin
                    fl = 1'b1;
                end
            end
            PH_OBJ_FIRST, PH_OBJ_KEY:
            begin
                if (ws)
                begin
                end
                else if (b == 8'h22)
                begin
                    key_next = 1'b1; phase_next = PH_STRING;
                end
                else if (b == 8'h7D && ph == PH_OBJ_FIRST)
                begin
                    closing = 1'b1;
                end
                else
                begin
                    fl = 1'b1; fcode = jst_pkg::E_EXPECT_QUOTE;
                end
            end
            PH_COLON:
            begin
                if (ws)
                begin
                end
                else if (b == 8'h3A)
                begin
                    phase_next = PH_VALUE;
                end
                else
                begin
                    fl = 1'b1; fcode = jst_pkg::E_EXPECT_COLON;
                end
            end
            PH_AFTER:
            begin
                after_chk = 1'b1;
            end
            PH_STRING:
            begin
                if (b == 8'h22)
                begin
                    if (key_reg && !start)
                    begin
                        e[0].kind = jst_pkg::K_KEYEND; n = 2'd1; phase_next = PH_COLON;
                    end
                    else
                    begin
                        e[0].kind = jst_pkg::K_STREND; n = 2'd1; vdone = 1'b1;
                    end
                end
                else if (b == 8'h5C)
                begin
                    phase_next = PH_ESCAPE;
                end
                else if (b == 8'h0D || b == 8'h0A || b == 8'h00)
                begin
                    fl = 1'b1; fcode = jst_pkg::E_UNTERMINATED;
                end
                else
                begin
                    e[0].kind = jst_pkg::K_STRBYTE; e[0].data_byte = b; n = 2'd1;
                end
            end
            PH_ESCAPE:
            begin
                ok = 1'b1;
                case (b)
                    8'h22, 8'h5C, 8'h2F: e[0].data_byte = b;
                    8'h62: e[0].data_byte = 8'h08;
                    8'h66: e[0].data_byte = 8'h0C;
                    8'h6E: e[0].data_byte = 8'h0A;
                    8'h72: e[0].data_byte = 8'h0D;
                    8'h74: e[0].data_byte = 8'h09;
                    8'h75:
                    begin
                        ok = 1'b0; hex_next = '0; hcnt_next = '0; phase_next = PH_HEX;
                    end
                    default:
                    begin
                        ok = 1'b0; fl = 1'b1; fcode = jst_pkg::E_BAD_ESCAPE;
                    end
                endcase
                if (ok)
                begin
                    e[0].kind = jst_pkg::K_STRBYTE; n = 2'd1; phase_next = PH_STRING;
                end
            end
            PH_HEX:
            begin
                if (!hok)
                begin
                    fl = 1'b1; fcode = jst_pkg::E_BAD_ESCAPE;
                end
                else
                begin
                    u = {hex_next[11:0], hv};
                    hex_next = u;
                    hcnt_next = hcnt_next + 3'd1;
                    if (hcnt_next >= 3'd4)
                    begin
                        hcnt_next = '0; phase_next = PH_STRING;
                        e[0].kind = jst_pkg::K_STRBYTE;
                        e[1].kind = jst_pkg::K_STRBYTE;
                        e[2].kind = jst_pkg::K_STRBYTE;
                        if (u <= 16'h007F)
                        begin
                            e[0].data_byte = u[7:0]; n = 2'd1;
                        end
                        else if (u <= 16'h07FF)
                        begin
                            e[0].data_byte = {3'b110, u[10:6]};
                            e[1].data_byte = {2'b10, u[5:0]}; n = 2'd2;
                        end
                        else
                        begin
                            e[0].data_byte = {4'b1110, u[15:12]};
                            e[1].data_byte = {2'b10, u[11:6]};
                            e[2].data_byte = {2'b10, u[5:0]}; n = 2'd3;
                        end
                    end
                end
            end
            PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXPDIG:
            begin
                if (dig)
                begin
                    e[0].kind = jst_pkg::K_NUMBYTE; e[0].data_byte = b; n = 2'd1;
                end
                else if (b == 8'h2E && ph == PH_NUM_INT)
                begin
                    e[0].kind = jst_pkg::K_NUMBYTE; e[0].data_byte = b; n = 2'd1;
                    phase_next = PH_NUM_FRAC;
                end
                else if ((b == 8'h65 || b == 8'h45) && ph == PH_NUM_FRAC)
                begin
                    e[0].kind = jst_pkg::K_NUMBYTE; e[0].data_byte = b; n = 2'd1;
                    phase_next = PH_NUM_EXPSIGN;
                end
                else
                begin
                    e[0].kind = jst_pkg::K_NUMEND; n = 2'd1; vdone = 1'b1;
                    after_chk = (lv != '0);
                end
            end
            PH_NUM_EXPSIGN:
            begin
                if (b == 8'h2B || b == 8'h2D || dig)
                begin
                    e[0].kind = jst_pkg::K_NUMBYTE; e[0].data_byte = b; n = 2'd1;
                    phase_next = PH_NUM_EXPDIG;
                end
                else
                begin
                    fl = 1'b1; fcode = jst_pkg::E_BAD_NUMBER;
                end
            end
            PH_LIT_TRUE, PH_LIT_FALSE, PH_LIT_NULL:
            begin
                llen = (ph == PH_LIT_FALSE) ? 3'd5 : 3'd4;
                case ({ph[1:0], lpos_next})
                    {PH_LIT_TRUE[1:0], 3'd0}:  want = 8'h74;
                    {PH_LIT_TRUE[1:0], 3'd1}:  want = 8'h72;
                    {PH_LIT_TRUE[1:0], 3'd2}:  want = 8'h75;
                    {PH_LIT_TRUE[1:0], 3'd3}:  want = 8'h65;
                    {PH_LIT_FALSE[1:0], 3'd0}: want = 8'h66;
                    {PH_LIT_FALSE[1:0], 3'd1}: want = 8'h61;
                    {PH_LIT_FALSE[1:0], 3'd2}: want = 8'h6C;
                    {PH_LIT_FALSE[1:0], 3'd3}: want = 8'h73;
                    {PH_LIT_FALSE[1:0], 3'd4}: want = 8'h65;
                    {PH_LIT_NULL[1:0], 3'd0}:  want = 8'h6E;
                    {PH_LIT_NULL[1:0], 3'd1}:  want = 8'h75;
                    {PH_LIT_NULL[1:0], 3'd2}:  want = 8'h6C;
                    {PH_LIT_NULL[1:0], 3'd3}:  want = 8'h6C;
                    default: want = 8'h00;
                endcase
                if (lpos_next >= llen || b != want)
                begin
                    fl = 1'b1;
                end
                else if (lpos_next + 3'd1 >= llen)
                begin
                    lpos_next = '0; vdone = 1'b1; n = 2'd1;
                    e[0].kind = (ph == PH_LIT_TRUE) ? jst_pkg::K_TRUE
                              : (ph == PH_LIT_FALSE) ? jst_pkg::K_FALSE : jst_pkg::K_NULL;
                end
                else
                begin
                    lpos_next = lpos_next + 3'd1;
                end
            end
            default:
            begin
            end
        endcase

        // Comma, closer or whitespace after a value (also the byte ending a number).
        if (after_chk && !ws)
        begin
            vdone = 1'b0;
            if (b == 8'h2C)
            begin
                phase_next = in_arr ? PH_VALUE : PH_OBJ_KEY;
            end
            else if (b == 8'h7D && !in_arr)
            begin
                closing = 1'b1;
            end
            else if (b == 8'h5D && in_arr)
            begin
                closing = 1'b1; close_arr = 1'b1;
            end
            else
            begin
                fl = 1'b1;
            end
        end
        else if (after_chk)
        begin
            vdone = 1'b0;
            phase_next = PH_AFTER;
        end

        for (int i = 0; i < 3; i++)
        begin
            e[i].nesting = 7'(lv);
        end
        // Events from a push or pop onward report the depth after it.
        if (opening)
        begin
            if ((LW+1)'(lv) >= lim)
            begin
                fl = 1'b1; fcode = jst_pkg::E_TOO_DEEP;
            end
            else
            begin
                cmd.push = 1'b1; cmd.is_array = open_arr;
                lv = lv + 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    if (2'(i) >= n)
                    begin
                        e[i].nesting = 7'(lv);
                    end
                end
                e[n].kind = open_arr ? jst_pkg::K_ARRBEG : jst_pkg::K_OBJBEG;
                n = n + 2'd1;
                phase_next = open_arr ? PH_VOC : PH_OBJ_FIRST;
            end
        end
        if (closing)
        begin
            if (lv != '0)
            begin
                lv = lv - 1'b1; cmd.pop = 1'b1;
            end
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) >= n)
                begin
                    e[i].nesting = 7'(lv);
                end
            end
            e[n].kind = close_arr ? jst_pkg::K_ARREND : jst_pkg::K_OBJEND;
            n = n + 2'd1;
            vdone = 1'b1;
        end
        if (vdone)
        begin
            if (lv == '0)
            begin
                e[n].kind = jst_pkg::K_DOCEND; n = n + 2'd1;
                phase_next = PH_DONE; done_next = 1'b1;
            end
            else
            begin
                phase_next = PH_AFTER;
            end
        end
        if (fl)
        begin
            e[n].kind = jst_pkg::K_ERROR; e[n].error_code = fcode;
            e[n].data_byte = '0; n = n + 2'd1;
            phase_next = PH_ERROR;
        end
        level_next = lv;
        if (!step)
        begin
            cmd = '0;
        end
        ev0 = e[0]; ev1 = e[1]; ev2 = e[2]; ev_cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VALUE; level_reg <= '0; hex_reg <= '0; hcnt_reg <= '0;
            lpos_reg <= '0; key_reg <= 1'b0; done_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next; level_reg <= level_next; hex_reg <= hex_next;
            hcnt_reg <= hcnt_next; lpos_reg <= lpos_next; key_reg <= key_next;
            done_reg <= done_next;
        end
    end
endmodule
`default_nettype wire

FILE: src/json_stream_tokenizer_top.sv
// A byte's first event is offered in the cycle after the byte is taken.
// One byte per cycle while each byte gives at most one event and the receiver does not
// stall; a byte giving more events holds the input until its last beat is taken.
// The container stack is a chain of one-bit cells that shift one place per push or pop.
// Reset (rst_n, asynchronous, active low) clears the lexer, depth register (64)
// and the result queue; stack cells are not reset.
`default_nettype none
`include "json_stream_tokenizer_top_defines.svh"
module json_stream_tokenizer_top #(
    parameter int MAX_NESTING = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  text_byte,
    input  wire logic        start_document,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       kind,
    output logic [7:0]       data_byte,
    output logic [2:0]       error_code,
    output logic [6:0]       nesting,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int LW = $clog2(MAX_NESTING + 1);

    logic [6:0] max_depth_reg;
    jst_pkg::stack_cmd_t cmd;
    logic top_is_array;
    jst_pkg::event_t ev0, ev1, ev2;
    logic [1:0] ev_cnt;
    logic step;

    // Result buffer: up to three pending beats of the current byte.
    jst_pkg::event_t q_reg [3];
    logic [1:0] cnt_reg, idx_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'(jst_pkg::ADDR_MAX_DEPTH)) ? {25'd0, max_depth_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= 7'd64;
        end
        else if (psel && penable && pwrite && paddr == 2'(jst_pkg::ADDR_MAX_DEPTH))
        begin
            max_depth_reg <= pwdata[6:0];
        end
    end

    logic draining_last;
    assign draining_last = (cnt_reg == '0) || (!out_stall && idx_reg + 2'd1 == cnt_reg);
    assign in_stall = !draining_last;
    assign step = in_valid && !in_stall;

    jst_lexer #(.MAX_NESTING(MAX_NESTING), .LW(LW)) u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .b            (text_byte),
        .start        (start_document),
        .max_depth    (max_depth_reg),
        .top_is_array (top_is_array),
        .cmd          (cmd),
        .ev0          (ev0),
        .ev1          (ev1),
        .ev2          (ev2),
        .ev_cnt       (ev_cnt)
    );

    jst_stack_chain #(.DEPTH(MAX_NESTING)) u_stack (
        .clk          (clk),
        .cmd          (cmd),
        .top_is_array (top_is_array)
    );

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            q_reg[0] <= ev0; q_reg[1] <= ev1; q_reg[2] <= ev2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0; idx_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= ev_cnt; idx_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            if (idx_reg + 2'd1 == cnt_reg)
            begin
                cnt_reg <= '0; idx_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    jst_pkg::event_t cur;
    assign cur = q_reg[idx_reg];
    assign out_valid  = cnt_reg != '0;
    assign kind       = cur.kind;
    assign data_byte  = cur.data_byte;
    assign error_code = cur.error_code;
    assign nesting    = cur.nesting;
    assign last       = (idx_reg + 2'd1 == cnt_reg);

    `JST_ASSERT_IMP(a_idx_in_range, out_valid, idx_reg < cnt_reg,
        "beat index beyond pending count")
    `JST_ASSERT_IMP(a_no_take_while_busy, step, draining_last,
        "byte taken while earlier beats remain")
    `JST_ASSERT_IMP(a_err_code_only, out_valid && kind != jst_pkg::K_ERROR,
        error_code == 3'd0, "error code set on a beat that is not an error")
endmodule
`default_nettype wire

FILE: sim/tb_token_checker.sv
`default_nettype none
module tb_token_checker #(
    parameter int MAX_NESTING = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  text_byte,
    input  wire logic        start_document,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [3:0]  kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic [2:0]  error_code,
    input  wire logic [6:0]  nesting,
    input  wire logic        last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               fail_count,
    output int               pending
);
    typedef enum logic [4:0] {
        S_VALUE, S_VALUE_OR_CLOSE, S_OBJ_FIRST, S_OBJ_KEY, S_COLON, S_AFTER,
        S_STRING, S_ESCAPE, S_HEX, S_INT, S_FRAC, S_EXP_SIGN, S_EXP_DIGIT,
        S_LIT_TRUE, S_LIT_FALSE, S_LIT_NULL, S_DONE, S_FAILED
    } lex_state_e;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data_byte;
        logic [2:0] error_code;
        logic [6:0] nesting;
        logic       last;
    } token_t;

    token_t     token_queue[$];
    token_t     byte_tokens[$];
    lex_state_e state;
    logic [6:0] depth_limit;
    logic       is_array_at[MAX_NESTING];
    int         level;
    logic [15:0] hex_acc;
    int         hex_count;
    int         lit_pos;
    logic       in_key;

    assign pending = token_queue.size();

    function automatic bit is_space(input logic [7:0] b);
        return b == 8'h20 || b == 8'h0D || b == 8'h09 || b == 8'h0A || b == 8'h0B;
    endfunction

    function automatic bit is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    task automatic push_token(input logic [3:0] k, input logic [7:0] d,
                              input logic [2:0] e);
        token_t t;
        if (byte_tokens.size() < 3)
        begin
            t = '{k, d, e, level[6:0], 1'b0};
            byte_tokens = {byte_tokens, t};
        end
    endtask

    task automatic raise_error(input logic [2:0] e);
        push_token(jst_pkg::K_ERROR, 8'd0, e);
        state = S_FAILED;
    endtask

    task automatic finish_value();
        if (level == 0)
        begin
            push_token(jst_pkg::K_DOCEND, 8'd0, 3'd0);
            state = S_DONE;
        end
        else
            state = S_AFTER;
    endtask

    task automatic open_nest(input bit arr);
        int lim;
        lim = (depth_limit < MAX_NESTING) ? depth_limit : MAX_NESTING;
        if (level >= lim)
            raise_error(jst_pkg::E_TOO_DEEP);
        else
        begin
            is_array_at[level] = arr;
            level++;
            push_token(arr ? jst_pkg::K_ARRBEG : jst_pkg::K_OBJBEG, 8'd0, 3'd0);
            state = arr ? S_VALUE_OR_CLOSE : S_OBJ_FIRST;
        end
    endtask

    task automatic close_nest(input bit arr);
        if (level > 0)
            level--;
        push_token(arr ? jst_pkg::K_ARREND : jst_pkg::K_OBJEND, 8'd0, 3'd0);
        finish_value();
    endtask

    task automatic begin_value(input logic [7:0] b, input bit may_close);
        if (is_space(b))
            return;
        if (b == "{") open_nest(1'b0);
        else if (b == "[") open_nest(1'b1);
        else if (b == "\"")
        begin
            in_key = 1'b0;
            state = S_STRING;
        end
        else if (b == "-" || is_num(b))
        begin
            push_token(jst_pkg::K_NUMBYTE, b, 3'd0);
            state = S_INT;
        end
        else if (b == "t") begin state = S_LIT_TRUE; lit_pos = 1; end
        else if (b == "f") begin state = S_LIT_FALSE; lit_pos = 1; end
        else if (b == "n") begin state = S_LIT_NULL; lit_pos = 1; end
        else if (b == "]" && may_close) close_nest(1'b1);
        else raise_error(jst_pkg::E_UNRECOGNIZED);
    endtask

    task automatic after_item(input logic [7:0] b);
        bit arr;
        arr = level > 0 && is_array_at[level-1];
        if (is_space(b))
            return;
        if (b == ",") state = arr ? S_VALUE : S_OBJ_KEY;
        else if (b == "}" && !arr) close_nest(1'b0);
        else if (b == "]" && arr) close_nest(1'b1);
        else raise_error(jst_pkg::E_UNRECOGNIZED);
    endtask

    task automatic close_number(input logic [7:0] b);
        push_token(jst_pkg::K_NUMEND, 8'd0, 3'd0);
        finish_value();
        if (state == S_AFTER)
            after_item(b);
    endtask

    task automatic literal_char(input logic [7:0] b);
        string word;
        int which;
        which = state - S_LIT_TRUE;
        word = (which == 0) ? "true" : (which == 1) ? "false" : "null";
        if (lit_pos >= word.len() || b != word[lit_pos])
        begin
            raise_error(jst_pkg::E_UNRECOGNIZED);
            return;
        end
        lit_pos++;
        if (lit_pos >= word.len())
        begin
            lit_pos = 0;
            push_token(4'(jst_pkg::K_TRUE + which), 8'd0, 3'd0);
            finish_value();
        end
    endtask

    task automatic escape_char(input logic [7:0] b);
        logic [7:0] d;
        case (b)
            "\"", "\\", "/": d = b;
            "b": d = 8'h08;
            "f": d = 8'h0C;
            "n": d = 8'h0A;
            "r": d = 8'h0D;
            "t": d = 8'h09;
            "u":
            begin
                hex_acc = '0;
                hex_count = 0;
                state = S_HEX;
                return;
            end
            default:
            begin
                raise_error(jst_pkg::E_BAD_ESCAPE);
                return;
            end
        endcase
        push_token(jst_pkg::K_STRBYTE, d, 3'd0);
        state = S_STRING;
    endtask

    task automatic hex_char(input logic [7:0] b);
        logic [3:0] v;
        if (is_num(b)) v = 4'(b - "0");
        else if (b >= "a" && b <= "f") v = 4'(b - "a" + 10);
        else if (b >= "A" && b <= "F") v = 4'(b - "A" + 10);
        else
        begin
            raise_error(jst_pkg::E_BAD_ESCAPE);
            return;
        end
        hex_acc = {hex_acc[11:0], v};
        hex_count++;
        if (hex_count < 4)
            return;
        if (hex_acc <= 16'h7F)
            push_token(jst_pkg::K_STRBYTE, hex_acc[7:0], 3'd0);
        else if (hex_acc <= 16'h7FF)
        begin
            push_token(jst_pkg::K_STRBYTE, 8'hC0 | hex_acc[10:6], 3'd0);
            push_token(jst_pkg::K_STRBYTE, {2'b10, hex_acc[5:0]}, 3'd0);
        end
        else
        begin
            push_token(jst_pkg::K_STRBYTE, {4'hE, hex_acc[15:12]}, 3'd0);
            push_token(jst_pkg::K_STRBYTE, {2'b10, hex_acc[11:6]}, 3'd0);
            push_token(jst_pkg::K_STRBYTE, {2'b10, hex_acc[5:0]}, 3'd0);
        end
        hex_count = 0;
        state = S_STRING;
    endtask

    task automatic clear_doc();
        state = S_VALUE;
        level = 0;
        hex_acc = '0;
        hex_count = 0;
        lit_pos = 0;
        in_key = 1'b0;
    endtask

    task automatic lex_byte(input logic [7:0] b, input logic fresh);
        byte_tokens.delete();
        if (fresh)
            clear_doc();
        case (state)
            S_VALUE: begin_value(b, 1'b0);
            S_VALUE_OR_CLOSE: begin_value(b, 1'b1);
            S_OBJ_FIRST, S_OBJ_KEY:
                if (!is_space(b))
                begin
                    if (b == "\"")
                    begin
                        in_key = 1'b1;
                        state = S_STRING;
                    end
                    else if (b == "}" && state == S_OBJ_FIRST) close_nest(1'b0);
                    else raise_error(jst_pkg::E_EXPECT_QUOTE);
                end
            S_COLON:
                if (!is_space(b))
                begin
                    if (b == ":") state = S_VALUE;
                    else raise_error(jst_pkg::E_EXPECT_COLON);
                end
            S_AFTER: after_item(b);
            S_STRING:
                if (b == "\"")
                begin
                    if (in_key)
                    begin
                        push_token(jst_pkg::K_KEYEND, 8'd0, 3'd0);
                        state = S_COLON;
                    end
                    else
                    begin
                        push_token(jst_pkg::K_STREND, 8'd0, 3'd0);
                        finish_value();
                    end
                end
                else if (b == "\\") state = S_ESCAPE;
                else if (b == 8'h0D || b == 8'h0A || b == 8'h00)
                    raise_error(jst_pkg::E_UNTERMINATED);
                else push_token(jst_pkg::K_STRBYTE, b, 3'd0);
            S_ESCAPE: escape_char(b);
            S_HEX: hex_char(b);
            S_INT:
                if (is_num(b)) push_token(jst_pkg::K_NUMBYTE, b, 3'd0);
                else if (b == ".")
                begin
                    push_token(jst_pkg::K_NUMBYTE, b, 3'd0);
                    state = S_FRAC;
                end
                else close_number(b);
            S_FRAC:
                if (is_num(b)) push_token(jst_pkg::K_NUMBYTE, b, 3'd0);
                else if (b == "e" || b == "E")
                begin
                    push_token(jst_pkg::K_NUMBYTE, b, 3'd0);
                    state = S_EXP_SIGN;
                end
                else close_number(b);
            S_EXP_SIGN:
                if (b == "+" || b == "-" || is_num(b))
                begin
                    push_token(jst_pkg::K_NUMBYTE, b, 3'd0);
                    state = S_EXP_DIGIT;
                end
                else raise_error(jst_pkg::E_BAD_NUMBER);
            S_EXP_DIGIT:
                if (is_num(b)) push_token(jst_pkg::K_NUMBYTE, b, 3'd0);
                else close_number(b);
            S_LIT_TRUE, S_LIT_FALSE, S_LIT_NULL: literal_char(b);
            default: ;
        endcase
        if (byte_tokens.size() > 0)
            byte_tokens[byte_tokens.size()-1].last = 1'b1;
        token_queue = {token_queue, byte_tokens};
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        token_t got;
        token_t exp_tok;
        if (!rst_n)
        begin
            fail_count = 0;
            depth_limit = 7'd64;
            token_queue.delete();
            clear_doc();
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 2'(jst_pkg::ADDR_MAX_DEPTH))
                depth_limit = pwdata[6:0];
            if (out_valid && !out_stall)
            begin
                got = '{kind, data_byte, error_code, nesting, last};
                if (token_queue.size() == 0)
                    report_mismatch($sformatf("unexpected token %h", got));
                else
                begin
                    exp_tok = token_queue.pop_front();
                    if (got !== exp_tok)
                        report_mismatch($sformatf(
                            {"got kind %0d data %h err %0d nest %0d last %b, ",
                             "want kind %0d data %h err %0d nest %0d last %b"},
                            got.kind, got.data_byte, got.error_code, got.nesting,
                            got.last, exp_tok.kind, exp_tok.data_byte,
                            exp_tok.error_code, exp_tok.nesting, exp_tok.last));
                end
            end
            if (in_valid && !in_stall)
                lex_byte(text_byte, start_document);
        end
    end
endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte = 8'd0;
    logic        start_document = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  kind;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
    logic [6:0]  nesting;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = 2'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_off = 1'b0;
    int          quiet_cycles = 0;

    localparam int WATCHDOG = 20000;

    always #1 clk = ~clk;

    json_stream_tokenizer_top u_top (.*);

    tb_token_checker u_chk (.*);

    // Receiver stall; a long hold-off overrides the random pattern.
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic fresh);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        start_document <= fresh;
        // The stall is settled by the falling edge and holds until the next rising edge.
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_text(input string s, input bit fresh);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], fresh && i == 0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_depth(input logic [6:0] v);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'(jst_pkg::ADDR_MAX_DEPTH);
        pwdata <= {25'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    function automatic string rand_value(input int lvl);
        string s;
        int n;
        int pick;
        pick = $urandom_range(lvl > 3 ? 5 : 7);
        case (pick)
            0: s = $sformatf("%0d", $urandom_range(999));
            1: s = $sformatf("-%0d.%0de%s%0d", $urandom_range(99), $urandom_range(99),
                             $urandom_range(1) ? "+" : "-", $urandom_range(9));
            2: s = $urandom_range(1) ? "true" : ($urandom_range(1) ? "false" : "null");
            3: s = "\"a\\n\\u00e9\\u20AC\\\"/\"";
            4:
            begin
                s = "\"";
                n = $urandom_range(4);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(32, 126) == 34 ? 8'h41 :
                                      $urandom_range(32, 126)))};
                s = {s, "\""};
                if (s.len() > 2 && s[s.len()-2] == "\\")
                    s[s.len()-2] = "x";
            end
            5: s = "3.5";
            6:
            begin
                s = "[";
                n = $urandom_range(3);
                for (int i = 0; i < n; i++)
                    s = {s, (i > 0) ? ", " : "", rand_value(lvl + 1)};
                s = {s, "]"};
            end
            default:
            begin
                s = "{";
                n = $urandom_range(3);
                for (int i = 0; i < n; i++)
                    s = {s, (i > 0) ? "," : "", "\"k\"\t: ", rand_value(lvl + 1)};
                s = {s, "}"};
            end
        endcase
        return s;
    endfunction

    task automatic random_docs(input int count);
        string s;
        for (int i = 0; i < count; )
        begin
            s = rand_value(0);
            if ($urandom_range(9) == 0)
                s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(3) == 0)
                s = {s, " ", string'(8'($urandom_range(255)))};
            else
                s = {s, " "};
            send_text(s, 1'b1);
            i += s.len();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: literals, escapes, numbers, empty containers, special cases.
        send_text("{\"a\":[true,false,null,-0.5e+3]}", 1'b1);
        send_text("\"\\u0041\\u07FF\\uFFFF\\b\\f\\r\\t\"", 1'b1);
        send_text("[]x", 1'b1);
        send_text("{}", 1'b1);
        send_text("12 ", 1'b1);
        send_text("1e", 1'b1);
        send_text("1.e,", 1'b1);
        send_text("[1,]", 1'b1);
        send_text("{\"a\":1,}", 1'b1);
        send_text("[}", 1'b1);
        send_text("{\"a\" 1}", 1'b1);
        send_text("\"\\q", 1'b1);
        send_text("\"\\u12g", 1'b1);
        send_text("tru ", 1'b1);
        send_beat(8'h00, 1'b1);
        send_text("\"ab", 1'b1);
        send_beat(8'h00, 1'b0);
        send_text("7", 1'b1);
        send_beat(8'h00, 1'b0);
        send_text("\v\t\r\n[ ]", 1'b1);
        send_beat(8'hFF, 1'b1);

        write_depth(7'd0);
        send_text("[", 1'b1);
        write_depth(7'd1);
        send_text("[[]]", 1'b1);
        write_depth(7'd127);
        send_text("[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[", 1'b1);
        send_text("[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[", 1'b0);
        write_depth(7'd64);

        send_idle_pct = 0;
        stall_pct = 0;
        random_docs(10);

        // The receiver holds off while bytes keep coming, so the input stalls.
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            send_text("[\"\\u20ac\\u20ac\\u20ac\",1,2,3,4,5,6,7,8,9,\"abcdefg\"]", 1'b1);
        join
        drain();

        send_idle_pct = 60;
        random_docs(8);
        send_idle_pct = 0;
        stall_pct = 60;
        random_docs(8);
        write_depth(7'd3);
        send_idle_pct = 35;
        stall_pct = 35;
        random_docs(10);
        write_depth(7'd2);
        send_idle_pct = 0;
        stall_pct = 0;
        random_docs(6);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+src
src/jst_pkg.sv
src/jst_stack_cell.sv
src/jst_stack_chain.sv
src/jst_lexer.sv
src/json_stream_tokenizer_top.sv
sim/tb_token_checker.sv
sim/tb.sv
